/* rtl/alarm_condition_table_core_macros.svh */
// Assertion macros used by the checker in act_checker.sv.
`ifndef ALARM_CONDITION_TABLE_CORE_MACROS_SVH
`define ALARM_CONDITION_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ACT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alarm table check failed");

// next-cycle implication
`define ACT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alarm table check failed");

`endif

/* rtl/act_pkg.sv */
package act_pkg;

   localparam int MAX_CONDITIONS = 16;
   localparam int CNT_W          = $clog2(MAX_CONDITIONS + 1);

   localparam logic [31:0] METHOD_ACK     = 32'd9111;
   localparam logic [31:0] METHOD_CONFIRM = 32'd9113;
   localparam logic [31:0] METHOD_RESPOND = 32'd9069;

   localparam logic [1:0] MODE_SET_ACTIVE = 2'd0;
   localparam logic [1:0] MODE_DIALOG     = 2'd1;
   localparam logic [1:0] MODE_METHOD     = 2'd2;

   localparam logic [3:0] ST_GOOD      = 4'd0;
   localparam logic [3:0] ST_BADARG    = 4'd1;
   localparam logic [3:0] ST_FULL      = 4'd2;
   localparam logic [3:0] ST_METHOD    = 4'd3;
   localparam logic [3:0] ST_UNKNOWN   = 4'd4;
   localparam logic [3:0] ST_ACKED     = 4'd5;
   localparam logic [3:0] ST_INACTIVE  = 4'd6;
   localparam logic [3:0] ST_RESPONSE  = 4'd7;
   localparam logic [3:0] ST_CONFIRMED = 4'd8;

   typedef struct packed {
      logic active;
      logic acked;
      logic retain;
      logic confirmed;
   } flags_type;

   // match information rippling down the row of cells
   typedef struct packed {
      logic      found;
      flags_type flags;
      logic      dialog;
      logic      allow_bit;
   } chain_type;

   // update broadcast from the control logic to all cells
   typedef struct packed {
      logic        commit;
      logic        write_dialog;
      logic        write_chosen;
      logic [31:0] key;
      flags_type   flags;
      logic        dialog;
      logic [31:0] allowed;
      logic [4:0]  chosen;
      logic [4:0]  resp_index;
   } cmd_type;

endpackage

/* rtl/act_cell.sv */
module act_cell
   import act_pkg::*;
(
   input  logic      clock,
   input  logic      valid,
   input  logic      alloc_sel,
   input  cmd_type   cmd,
   input  chain_type chain_in,
   output chain_type chain_out
);

   logic [31:0] key_ff;
   flags_type   flags_ff;
   logic        dialog_ff;
   logic [31:0] allowed_ff;
   logic [4:0]  chosen_ff;

   logic      hit;
   logic      sel;
   chain_type mine;

   assign hit = valid && (key_ff == cmd.key);
   assign sel = hit || alloc_sel;

   always_comb begin
      mine.found     = hit;
      mine.flags     = hit ? flags_ff : '0;
      mine.dialog    = hit && dialog_ff;
      mine.allow_bit = hit && allowed_ff[cmd.resp_index];
      chain_out      = chain_in | mine;
   end

   // an allocated cell gets every field written, so no reset is needed
   always_ff @(posedge clock) begin
      if (cmd.commit && sel) begin
         key_ff   <= cmd.key;
         flags_ff <= cmd.flags;
         if (cmd.write_dialog) begin
            dialog_ff  <= cmd.dialog;
            allowed_ff <= cmd.allowed;
         end
         if (cmd.write_chosen) begin
            chosen_ff <= cmd.chosen;
         end
      end
   end

   // chosen response is stored state only; nothing reads it back
   logic unused_chosen;
   assign unused_chosen = ^chosen_ff;

endmodule

/* rtl/alarm_condition_table_core.sv */
// channel  | direction | handshake              | payload
// request  | in        | req_valid / req_ready  | req_mode .. req_response_value
// response | out       | rsp_valid / rsp_ready  | rsp_status, rsp_*_now
//
// Each request is accepted in S_IDLE; in S_LOOK the key match across the
// row of cells and the flag update load the response register.
// The match ripples through all MAX_CONDITIONS cells within S_LOOK.
// A new request is taken while the last response waits; a held response
// stalls the lookup cycle of the next one.
// Synchronous active-high reset clears the fill count and handshake state.
module alarm_condition_table_core
   import act_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_condition_key,
   input  logic        req_active_flag,
   input  logic [31:0] req_response_mask,
   input  logic [31:0] req_method_number,
   input  logic        req_method_numeric_ns0,
   input  logic        req_has_argument,
   input  logic signed [31:0] req_response_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic        rsp_active_now,
   output logic        rsp_acked_now,
   output logic        rsp_retain_now,
   output logic        rsp_confirmed_now
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LOOK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic [31:0] key_ff;
   logic        want_ff;
   logic [31:0] mask_ff;
   logic [31:0] method_ff;
   logic        ns0_ff;
   logic        has_arg_ff;
   logic [31:0] raw_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       status_ff;
   flags_type        out_flags_ff;

   chain_type chain [0:MAX_CONDITIONS];
   cmd_type   cmd;

   logic      req_fire, out_free, commit;
   logic      found, full, alloc_ok, exists, do_update;
   flags_type base, nf;
   logic [3:0] status;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_LOOK) && out_free;

   assign chain[0] = '0;

   for (genvar i = 0; i < MAX_CONDITIONS; i++) begin : g_cell
      act_cell u_cell (
         .clock     (clock),
         .valid     (CNT_W'(i) < count_ff),
         .alloc_sel (alloc_ok && (count_ff == CNT_W'(i))),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   always_comb begin
      found     = chain[MAX_CONDITIONS].found;
      full      = (count_ff == CNT_W'(MAX_CONDITIONS));
      base      = chain[MAX_CONDITIONS].flags;
      nf        = base;
      status    = ST_METHOD;
      alloc_ok  = 1'b0;
      do_update = 1'b0;

      cmd.write_dialog = 1'b0;
      cmd.write_chosen = 1'b0;
      cmd.dialog       = 1'b1;
      cmd.allowed      = mask_ff;
      cmd.chosen       = raw_ff[4:0];

      case (mode_ff)
         MODE_SET_ACTIVE, MODE_DIALOG: begin
            if (!found && full) begin
               status = ST_FULL;
            end else begin
               status    = ST_GOOD;
               do_update = 1'b1;
               if (!found) begin
                  // fresh entry starts cleared
                  alloc_ok         = 1'b1;
                  base             = '0;
                  cmd.write_dialog = 1'b1;
                  cmd.write_chosen = 1'b1;
                  cmd.dialog       = 1'b0;
                  cmd.allowed      = '0;
                  cmd.chosen       = '0;
               end
               nf = base;
               if (mode_ff == MODE_SET_ACTIVE) begin
                  if (base.active != want_ff) begin
                     nf.active = want_ff;
                     if (want_ff) begin
                        nf.acked  = 1'b0;
                        nf.retain = 1'b1;
                     end else if (base.acked) begin
                        nf.retain = 1'b0;
                     end
                  end
               end else begin
                  cmd.write_dialog = 1'b1;
                  cmd.dialog       = 1'b1;
                  cmd.allowed      = mask_ff;
                  nf.active        = 1'b1;
                  nf.retain        = 1'b1;
               end
            end
         end
         MODE_METHOD: begin
            if (!ns0_ff) begin
               status = ST_METHOD;
            end else if (method_ff == METHOD_ACK) begin
               if (!found) begin
                  status = ST_UNKNOWN;
               end else if (base.acked) begin
                  status = ST_ACKED;
               end else begin
                  status    = ST_GOOD;
                  do_update = 1'b1;
                  nf.acked  = 1'b1;
                  if (!base.active) begin
                     nf.retain = 1'b0;
                  end
               end
            end else if (method_ff == METHOD_RESPOND) begin
               if (!found || !chain[MAX_CONDITIONS].dialog) begin
                  status = ST_UNKNOWN;
               end else if (!base.active) begin
                  status = ST_INACTIVE;
               end else if (!has_arg_ff) begin
                  status = ST_BADARG;
               end else if (raw_ff[31:5] != '0 || !chain[MAX_CONDITIONS].allow_bit) begin
                  // negative values land here too
                  status = ST_RESPONSE;
               end else begin
                  status           = ST_GOOD;
                  do_update        = 1'b1;
                  cmd.write_chosen = 1'b1;
                  nf.active        = 1'b0;
                  nf.retain        = 1'b0;
               end
            end else if (method_ff == METHOD_CONFIRM) begin
               if (!found) begin
                  status = ST_UNKNOWN;
               end else if (base.confirmed) begin
                  status = ST_CONFIRMED;
               end else begin
                  status       = ST_GOOD;
                  do_update    = 1'b1;
                  nf.confirmed = 1'b1;
               end
            end else begin
               status = ST_METHOD;
            end
         end
         default: begin
            status = ST_METHOD;
         end
      endcase

      exists     = found || alloc_ok;
      cmd.commit = commit && do_update;
      cmd.key    = key_ff;
      cmd.flags  = nf;
      cmd.resp_index = raw_ff[4:0];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (alloc_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_mode;
         key_ff     <= req_condition_key;
         want_ff    <= req_active_flag;
         mask_ff    <= req_response_mask;
         method_ff  <= req_method_number;
         ns0_ff     <= req_method_numeric_ns0;
         has_arg_ff <= req_has_argument;
         raw_ff     <= req_response_value;
      end
      if (commit) begin
         status_ff    <= status;
         out_flags_ff <= exists ? nf : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_active_now    = out_flags_ff.active;
   assign rsp_acked_now     = out_flags_ff.acked;
   assign rsp_retain_now    = out_flags_ff.retain;
   assign rsp_confirmed_now = out_flags_ff.confirmed;

endmodule

/* rtl/act_checker.sv */
`include "alarm_condition_table_core_macros.svh"

module act_checker
   import act_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_status,
   input logic       rsp_active_now,
   input logic       rsp_acked_now,
   input logic       rsp_retain_now,
   input logic       rsp_confirmed_now
);

   logic any_flag;
   assign any_flag = rsp_active_now || rsp_acked_now || rsp_retain_now || rsp_confirmed_now;

   // a held response keeps its status
   `ACT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

   // status codes stop at already confirmed
   `ACT_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= ST_CONFIRMED)

   // table full means no entry, so all flags read zero
   `ACT_ASSERT_NOW(a_full_no_flags, rsp_valid && rsp_status == ST_FULL, !any_flag)

   // a request in flight blocks the next one for the lookup cycle
   `ACT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

bind alarm_condition_table_core act_checker u_act_checker (.*);

/* tb/sv/alarm_condition_table_check.sv */
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the condition table and
// compares every response with the outcome predicted for its request.
module alarm_condition_table_check
   import act_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_condition_key,
   input  logic        req_active_flag,
   input  logic [31:0] req_response_mask,
   input  logic [31:0] req_method_number,
   input  logic        req_method_numeric_ns0,
   input  logic        req_has_argument,
   input  logic [31:0] req_response_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_status,
   input  logic        rsp_active_now,
   input  logic        rsp_acked_now,
   input  logic        rsp_retain_now,
   input  logic        rsp_confirmed_now,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [3:0] status;
      flags_type  flags;
   } alarm_result_type;

   int unsigned      entries_used;
   logic [31:0]      cond_key     [MAX_CONDITIONS];
   flags_type        cond_flags   [MAX_CONDITIONS];
   logic             cond_dialog  [MAX_CONDITIONS];
   logic [31:0]      cond_allowed [MAX_CONDITIONS];
   alarm_result_type pending_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // lowest matching slot, -1 if the key is not in the table
   function automatic int locate_condition(logic [31:0] key);
      for (int i = 0; i < int'(entries_used); i++) begin
         if (cond_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int claim_condition(logic [31:0] key);
      int idx;
      idx = locate_condition(key);
      if (idx >= 0) return idx;
      if (entries_used >= MAX_CONDITIONS) return -1;
      idx = int'(entries_used);
      entries_used++;
      cond_key[idx]     = key;
      cond_flags[idx]   = '0;
      cond_dialog[idx]  = 1'b0;
      cond_allowed[idx] = '0;
      return idx;
   endfunction

   function automatic alarm_result_type next_alarm_result(
      logic [1:0] mode, logic [31:0] key, logic want_active, logic [31:0] mask,
      logic [31:0] method, logic ns0, logic has_arg, logic [31:0] value);
      alarm_result_type res;
      int idx;
      res = '0;
      if (mode == MODE_SET_ACTIVE) begin
         idx = claim_condition(key);
         if (idx < 0) begin
            res.status = ST_FULL;
         end else begin
            if (cond_flags[idx].active != want_active) begin
               cond_flags[idx].active = want_active;
               if (want_active) begin
                  cond_flags[idx].acked  = 1'b0;
                  cond_flags[idx].retain = 1'b1;
               end else if (cond_flags[idx].acked) begin
                  cond_flags[idx].retain = 1'b0;
               end
            end
            res.status = ST_GOOD;
         end
      end else if (mode == MODE_DIALOG) begin
         idx = claim_condition(key);
         if (idx < 0) begin
            res.status = ST_FULL;
         end else begin
            cond_dialog[idx]         = 1'b1;
            cond_allowed[idx]        = mask;
            cond_flags[idx].active   = 1'b1;
            cond_flags[idx].retain   = 1'b1;
            res.status = ST_GOOD;
         end
      end else if (mode == MODE_METHOD) begin
         idx = locate_condition(key);
         if (!ns0) begin
            res.status = ST_METHOD;
         end else if (method == METHOD_ACK) begin
            if (idx < 0) res.status = ST_UNKNOWN;
            else if (cond_flags[idx].acked) res.status = ST_ACKED;
            else begin
               cond_flags[idx].acked = 1'b1;
               if (!cond_flags[idx].active) cond_flags[idx].retain = 1'b0;
               res.status = ST_GOOD;
            end
         end else if (method == METHOD_RESPOND) begin
            if (idx < 0 || !cond_dialog[idx]) res.status = ST_UNKNOWN;
            else if (!cond_flags[idx].active) res.status = ST_INACTIVE;
            else if (!has_arg) res.status = ST_BADARG;
            // unsigned compare: negative values land above 31
            else if (value > 32'd31) res.status = ST_RESPONSE;
            else if (!cond_allowed[idx][value[4:0]]) res.status = ST_RESPONSE;
            else begin
               cond_flags[idx].active = 1'b0;
               cond_flags[idx].retain = 1'b0;
               res.status = ST_GOOD;
            end
         end else if (method == METHOD_CONFIRM) begin
            if (idx < 0) res.status = ST_UNKNOWN;
            else if (cond_flags[idx].confirmed) res.status = ST_CONFIRMED;
            else begin
               cond_flags[idx].confirmed = 1'b1;
               res.status = ST_GOOD;
            end
         end else begin
            res.status = ST_METHOD;
         end
      end else begin
         // spare mode: lookup only, nothing changes
         idx = locate_condition(key);
         res.status = ST_METHOD;
      end
      if (idx >= 0) res.flags = cond_flags[idx];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      alarm_result_type want;
      alarm_result_type got;
      if (reset) begin
         entries_used = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.flags  = '{rsp_active_now, rsp_acked_now, rsp_retain_now, rsp_confirmed_now};
            if (pending_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with none outstanding: status %0d flags %b",
                           $realtime, got.status, got.flags);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.status != want.status || got.flags.active != want.flags.active ||
                   got.flags.acked != want.flags.acked ||
                   got.flags.retain != want.flags.retain ||
                   got.flags.confirmed != want.flags.confirmed) begin
                  if (mismatches < 10)
                     $display("%0t: status exp %0d got %0d, flags (a/k/r/c) exp %b got %b",
                              $realtime, want.status, got.status, want.flags, got.flags);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(next_alarm_result(req_mode, req_condition_key,
               req_active_flag, req_response_mask, req_method_number,
               req_method_numeric_ns0, req_has_argument, req_response_value));
      end
      outstanding = pending_results.size();
   end

endmodule

/* tb/sv/tb_alarm_condition_table_core.sv */
`timescale 1ns / 100ps

module tb_alarm_condition_table_core;
   import act_pkg::*;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         RANDOM_REQS  = 1080;
   localparam int         STALL_LIMIT  = 400;
   localparam int         LONG_HOLD    = 40;

   typedef struct {
      logic [1:0]         mode;
      logic [31:0]        key;
      logic               active;
      logic [31:0]        mask;
      logic [31:0]        method;
      logic               ns0;
      logic               arg;
      logic signed [31:0] value;
   } alarm_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [31:0] req_condition_key;
   logic        req_active_flag;
   logic [31:0] req_response_mask;
   logic [31:0] req_method_number;
   logic        req_method_numeric_ns0;
   logic        req_has_argument;
   logic signed [31:0] req_response_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_status;
   logic        rsp_active_now;
   logic        rsp_acked_now;
   logic        rsp_retain_now;
   logic        rsp_confirmed_now;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   bit no_idle     = 1'b0;
   bit hold_off    = 1'b0;

   always #6 clock = ~clock;

   alarm_condition_table_core uut (.*);

   alarm_condition_table_check table_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_condition_key, .req_active_flag,
      .req_response_mask, .req_method_number, .req_method_numeric_ns0,
      .req_has_argument, .req_response_value,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_active_now, .rsp_acked_now,
      .rsp_retain_now, .rsp_confirmed_now,
      .mismatches, .outstanding
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_request(input alarm_req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_mode               <= r.mode;
      req_condition_key      <= r.key;
      req_active_flag        <= r.active;
      req_response_mask      <= r.mask;
      req_method_number      <= r.method;
      req_method_numeric_ns0 <= r.ns0;
      req_has_argument       <= r.arg;
      req_response_value     <= r.value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic issue(input logic [1:0] mode, input logic [31:0] key, input logic active,
                        input logic [31:0] mask, input logic [31:0] method,
                        input logic ns0, input logic arg, input logic signed [31:0] value);
      alarm_req_type r;
      r = '{mode, key, active, mask, method, ns0, arg, value};
      push_request(r);
   endtask

   // response side
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            stall    = LONG_HOLD;
            hold_off = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : req_side
      logic [31:0]   key_pool [16];
      alarm_req_type r;
      int            pick;
      req_valid              = 1'b0;
      req_mode               = MODE_SET_ACTIVE;
      req_condition_key      = '0;
      req_active_flag        = 1'b0;
      req_response_mask      = '0;
      req_method_number      = '0;
      req_method_numeric_ns0 = 1'b0;
      req_has_argument       = 1'b0;
      req_response_value     = '0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 16; i++) key_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, lookups and each method path
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_ACK, 1, 1, 0);      // unknown node
      issue(MODE_SPARE, key_pool[0], 0, 0, 0, 1, 1, 0);                // no entry
      issue(MODE_SET_ACTIVE, key_pool[0], 1, 0, 0, 0, 0, 0);
      issue(MODE_SET_ACTIVE, key_pool[1], 0, 0, 0, 0, 0, 0);
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_ACK, 1, 0, 0);
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_ACK, 1, 0, 0);      // already acked
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_CONFIRM, 1, 0, 0);
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_CONFIRM, 1, 0, 0);  // already confirmed
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_RESPOND, 1, 1, 0);  // not a dialog
      issue(MODE_DIALOG, key_pool[1], 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 0, 3);  // no argument
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 1, -32'sd1);
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 1, 32'sh8000_0000);
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 1, 32'sd32);
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 1, 32'sd31);
      issue(MODE_METHOD, key_pool[1], 0, 0, METHOD_RESPOND, 1, 1, 32'sd0); // inactive
      issue(MODE_METHOD, key_pool[0], 0, 0, METHOD_ACK, 0, 0, 0);      // not ns0
      issue(MODE_METHOD, key_pool[0], 0, 0, 32'hFFFF_FFFF, 1, 0, 0);   // unknown method
      issue(MODE_DIALOG, key_pool[2], 0, 32'h0000_0000, 0, 0, 0, 0);
      issue(MODE_METHOD, key_pool[2], 0, 0, METHOD_RESPOND, 1, 1, 32'sd0); // not allowed
      issue(MODE_SET_ACTIVE, key_pool[0], 0, 0, 0, 0, 0, 0);           // acked: retain drops
      issue(MODE_SPARE, key_pool[0], 1, 32'hFFFF_FFFF, METHOD_ACK, 1, 1, 32'sd1);
      issue(MODE_METHOD, 32'h1234_5678, 0, 0, METHOD_CONFIRM, 1, 0, 0); // unknown node

      // random: mostly pool keys so the flag sequences run deep,
      // some fresh keys that allocate early and hit a full table later
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == 400) begin
            hold_off = 1'b1;
            no_idle  = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30)      r.mode = MODE_SET_ACTIVE;
         else if (pick < 45) r.mode = MODE_DIALOG;
         else if (pick < 95) r.mode = MODE_METHOD;
         else                r.mode = MODE_SPARE;
         r.key    = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
         r.active = 1'($urandom_range(0, 1));
         r.mask   = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 30)      r.method = METHOD_ACK;
         else if (pick < 50) r.method = METHOD_CONFIRM;
         else if (pick < 90) r.method = METHOD_RESPOND;
         else                r.method = $urandom;
         r.ns0 = ($urandom_range(0, 9) != 0);
         r.arg = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 8)       r.value = $urandom_range(0, 31);
         else if (pick == 8) r.value = $urandom;
         else                r.value = $urandom_range(32, 40);
         push_request(r);
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
